/* sv/mvsm_pkg.sv */
// mvsm_pkg: shared types, codes and the volume function of the voice mixer.
// No dependencies.
package mvsm_pkg;

   localparam int LEN_W         = 19;
   localparam int NUM_LEN_REGS  = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int LOOP_VOICE_W  = 2;
   localparam int SAMPLE_W      = 32;
   localparam int VOL_W         = 4;

   localparam logic [CSR_IDX_W-1:0]    CSR_LOOP_VOICE    = 3'd4;
   localparam logic [LOOP_VOICE_W-1:0] LOOP_VOICE_RESET  = 2'd3;

   typedef enum logic [2:0] {
      OP_LOAD   = 3'd0,
      OP_START  = 3'd1,
      OP_LOOP   = 3'd2,
      OP_VOLUME = 3'd3,
      OP_TICK   = 3'd4
   } op_type;

   localparam logic [VOL_W-1:0] VOL_QUARTER = 4'h0;
   localparam logic [VOL_W-1:0] VOL_HALF    = 4'h1;
   localparam logic [VOL_W-1:0] VOL_UNITY   = 4'h3;
   localparam logic [VOL_W-1:0] VOL_DOUBLE  = 4'h7;
   localparam logic [VOL_W-1:0] VOL_QUAD    = 4'hF;

   function automatic logic [SAMPLE_W-1:0] apply_volume(input logic [SAMPLE_W-1:0] s,
                                                        input logic [VOL_W-1:0] code);
      logic [SAMPLE_W-1:0] r;
      case (code)
         VOL_QUARTER: r = s >> 2;
         VOL_HALF:    r = s >> 1;
         VOL_UNITY:   r = s;
         VOL_DOUBLE:  r = s << 1;
         VOL_QUAD:    r = s << 2;
         default:     r = '0;
      endcase
      return r;
   endfunction

endpackage

/* sv/multi_voice_sample_mixer_top.sv */
// Multi-voice sample mixer top level: sample memory, voice state and tick sequencer.
// Depends on mvsm_pkg.
//
// Load, start, loop and volume transactions take effect at the accepting edge. A tick
// reads the single-port sample memory once per voice and stalls other requests until
// every voice is read (one read per cycle unless the output is held, voice 0 in the
// accept cycle); a new request is taken once busy clears. The mixed sum is registered
// after the last read and may wait in the output register while the next transaction
// is accepted. Sample memory has no reset; only written words are valid.
module multi_voice_sample_mixer_top #(
   parameter int VOICES      = 4,
   parameter int MAX_SAMPLES = 262144
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_operation,
   input  logic [1:0]                           req_voice,
   input  logic [17:0]                          req_sample_address,
   input  logic [31:0]                          req_sample_value,
   input  logic [3:0]                           req_volume_switches,
   input  logic                                 req_loop_flag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [31:0]                          rsp_mixed_sample,
   output logic                                 rsp_any_active,
   input  logic                                 csr_we,
   input  logic [mvsm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mvsm_pkg::LEN_W-1:0]           csr_data
);

   localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int POS_W  = $clog2(MAX_SAMPLES);
   localparam int PLEN_W = $clog2(MAX_SAMPLES + 1);
   localparam int CW     = PLEN_W + 1;
   localparam int DEPTH  = VOICES * MAX_SAMPLES;
   localparam int AW     = $clog2(DEPTH);

   // voice state
   logic                                    active_ff [VOICES];
   logic [POS_W-1:0]                        pos_ff    [VOICES];
   logic [mvsm_pkg::VOL_W-1:0]              vol_ff    [VOICES];
   logic [mvsm_pkg::LEN_W-1:0]              len_ff    [VOICES];
   logic                                    loop_en_ff;
   logic [mvsm_pkg::LOOP_VOICE_W-1:0]       loop_voice_ff;

   // sequencer
   logic                                    busy_ff;
   logic [VW-1:0]                           issue_cnt_ff;

   // accumulate stage
   logic                                    acc_valid_ff;
   logic                                    acc_first_ff;
   logic                                    acc_last_ff;
   logic                                    acc_add_ff;
   logic                                    acc_act_ff;
   logic [mvsm_pkg::VOL_W-1:0]              acc_vol_ff;
   logic [31:0]                             sum_ff;
   logic                                    any_ff;
   logic [31:0]                             sum_in;
   logic                                    any_in;

   // output register
   logic                                    rsp_valid_ff;
   logic [31:0]                             rsp_sum_ff;
   logic                                    rsp_any_ff;

   // sample memory
   logic [31:0]                             mem [DEPTH];
   logic [31:0]                             mem_q_ff;
   logic [AW-1:0]                           wr_addr;
   logic [AW-1:0]                           rd_addr;
   logic                                    mem_we;

   logic                                    advance;
   logic                                    accept;
   logic                                    issue_go;
   logic [VW-1:0]                           issue_voice;
   logic                                    iss_act;
   logic [PLEN_W-1:0]                       iss_len;
   logic [POS_W-1:0]                        iss_pos;
   logic                                    iss_end;
   logic                                    iss_loops;
   logic                                    req_voice_ok;

   assign advance  = !(acc_valid_ff && acc_last_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = busy_ff || !advance;
   assign accept   = req_valid && !req_stall;
   assign issue_go = advance && (busy_ff || (accept && req_operation == mvsm_pkg::OP_TICK));
   assign req_voice_ok = 32'(req_voice) < VOICES;
   assign mem_we   = accept && req_operation == mvsm_pkg::OP_LOAD && req_voice_ok
                     && 32'(req_sample_address) < MAX_SAMPLES;

   always_comb begin
      issue_voice = busy_ff ? issue_cnt_ff : '0;
      iss_act     = active_ff[issue_voice];
      iss_pos     = pos_ff[issue_voice];
      if (32'(len_ff[issue_voice]) > MAX_SAMPLES) begin
         iss_len = PLEN_W'(MAX_SAMPLES);
      end else begin
         iss_len = PLEN_W'(len_ff[issue_voice]);
      end
      iss_end   = (CW'(iss_pos) + CW'(1)) >= CW'(iss_len);
      iss_loops = loop_en_ff && (32'(loop_voice_ff) == 32'(issue_voice));
      rd_addr   = AW'(32'(issue_voice) * MAX_SAMPLES) + AW'(iss_pos);
      wr_addr   = AW'(32'(req_voice) * MAX_SAMPLES) + AW'(req_sample_address);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_sample_value;
      end
      if (issue_go) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            active_ff[v] <= 1'b0;
            pos_ff[v]    <= '0;
            vol_ff[v]    <= mvsm_pkg::VOL_UNITY;
            len_ff[v]    <= '0;
         end
         loop_en_ff    <= 1'b0;
         loop_voice_ff <= mvsm_pkg::LOOP_VOICE_RESET;
         busy_ff       <= 1'b0;
         issue_cnt_ff  <= '0;
         acc_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            for (int v = 0; v < VOICES; v++) begin
               if (v < mvsm_pkg::NUM_LEN_REGS && 32'(csr_index) == v) begin
                  len_ff[v] <= csr_data;
               end
            end
            if (csr_index == mvsm_pkg::CSR_LOOP_VOICE) begin
               loop_voice_ff <= csr_data[mvsm_pkg::LOOP_VOICE_W-1:0];
            end
         end

         if (accept) begin
            case (req_operation)
               mvsm_pkg::OP_START: begin
                  for (int v = 0; v < VOICES; v++) begin
                     if (32'(req_voice) == v) begin
                        active_ff[v] <= 1'b1;
                        pos_ff[v]    <= '0;
                     end
                  end
               end
               mvsm_pkg::OP_LOOP: loop_en_ff <= req_loop_flag;
               mvsm_pkg::OP_VOLUME: begin
                  for (int v = 0; v < VOICES; v++) begin
                     if (active_ff[v]) begin
                        vol_ff[v] <= req_volume_switches;
                     end
                  end
               end
               default: ;
            endcase
         end

         if (issue_go) begin
            if (iss_act) begin
               if (iss_len == '0) begin
                  active_ff[issue_voice] <= 1'b0;
                  pos_ff[issue_voice]    <= '0;
               end else if (iss_end) begin
                  pos_ff[issue_voice] <= '0;
                  if (!iss_loops) begin
                     active_ff[issue_voice] <= 1'b0;
                  end
               end else begin
                  pos_ff[issue_voice] <= iss_pos + POS_W'(1);
               end
            end
            if (issue_voice == VW'(VOICES - 1)) begin
               busy_ff <= 1'b0;
            end else begin
               busy_ff      <= 1'b1;
               issue_cnt_ff <= issue_voice + VW'(1);
            end
         end

         if (advance) begin
            acc_valid_ff <= issue_go;
         end

         if (acc_valid_ff && acc_last_ff && advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sum_in = (acc_first_ff ? 32'd0 : sum_ff)
               + (acc_add_ff ? mvsm_pkg::apply_volume(mem_q_ff, acc_vol_ff) : 32'd0);
      any_in = (acc_first_ff ? 1'b0 : any_ff) | acc_act_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (issue_go) begin
            acc_first_ff <= issue_voice == '0;
            acc_last_ff  <= issue_voice == VW'(VOICES - 1);
            acc_act_ff   <= iss_act;
            acc_add_ff   <= iss_act && iss_len != '0;
            acc_vol_ff   <= vol_ff[issue_voice];
         end
         if (acc_valid_ff) begin
            sum_ff <= sum_in;
            any_ff <= any_in;
            if (acc_last_ff) begin
               rsp_sum_ff <= sum_in;
               rsp_any_ff <= any_in;
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sum_ff;
   assign rsp_any_active   = rsp_any_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> req_stall)
      else $error("transaction accepted during tick sequence");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (32'(issue_cnt_ff) < VOICES))
      else $error("issue counter out of range");

   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      !active_ff[0] |-> (pos_ff[0] == '0))
      else $error("inactive voice keeps a play position");

   a_port_conflict: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !issue_go)
      else $error("sample write collides with tick read");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      acc_valid_ff && acc_last_ff && !advance |=> acc_valid_ff && acc_last_ff)
      else $error("final voice sum dropped while output held");

endmodule
